/* design/nsc_pkg.sv */
// Shared types, constants and the class table for the neighbour shell classifier.
package nsc_pkg;

  // Field widths of a request and a result.
  localparam int unsigned FIRST_W   = 4;
  localparam int unsigned SECOND_W  = 12;
  localparam int unsigned SCORE_W   = 3;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned CLASS_W   = 5;
  localparam int unsigned MAIN_W    = 2;
  localparam int unsigned CODE_W    = 24;
  localparam int unsigned NUM_CLASSES = 31;

  // Packed bus widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [CODE_W-1:0]  code_t;

  // One input request after unpacking.
  typedef struct packed {
    logic                centre_present;
    logic [FIRST_W-1:0]  first_present;
    logic [SECOND_W-1:0] second_present;
  } nsc_request_t;

  // One classification result.
  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic               is_error;
    logic [MAIN_W-1:0]  main_type;
  } nsc_result_t;

  // Sorted score triples, largest score in the lowest byte, in class order.
  localparam code_t CLASS_CODES [NUM_CLASSES] = '{
    24'h000002, 24'h000003, 24'h000004,
    24'h000102, 24'h000103, 24'h000104, 24'h000202, 24'h000203,
    24'h000204, 24'h000303, 24'h000304, 24'h000404,
    24'h010102, 24'h010103, 24'h010104, 24'h010202, 24'h010203,
    24'h010204, 24'h010303, 24'h010304, 24'h010404, 24'h020202,
    24'h020203, 24'h020204, 24'h020303, 24'h020304, 24'h020404,
    24'h030303, 24'h030304, 24'h030404, 24'h040404
  };

endpackage

/* design/nsc_classify.sv */
// Combinational scoring, sorting and table lookup for one neighbourhood.
module nsc_classify (
  input  nsc_pkg::nsc_request_t req,
  output nsc_pkg::nsc_result_t  res
);

  nsc_pkg::score_t                score [4];
  nsc_pkg::score_t                a0, a1, a2, a3;
  nsc_pkg::score_t                b0, b1, b2;
  nsc_pkg::score_t                s0, s1, s2;
  logic [nsc_pkg::COUNT_W-1:0]    count;
  nsc_pkg::code_t                 code;
  logic                           found;
  logic [nsc_pkg::CLASS_W-1:0]    match_index;
  logic                           count_ok;

  // Score each first neighbour: one plus its occupied second neighbours.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (req.first_present[k]) begin
        score[k] = nsc_pkg::SCORE_W'(1)
                 + nsc_pkg::SCORE_W'(req.second_present[3*k])
                 + nsc_pkg::SCORE_W'(req.second_present[3*k+1])
                 + nsc_pkg::SCORE_W'(req.second_present[3*k+2]);
      end else begin
        score[k] = '0;
      end
    end
  end

  // Count the present first neighbours.
  assign count = nsc_pkg::COUNT_W'(req.first_present[0])
               + nsc_pkg::COUNT_W'(req.first_present[1])
               + nsc_pkg::COUNT_W'(req.first_present[2])
               + nsc_pkg::COUNT_W'(req.first_present[3]);

  // Five compare-exchange sorting network, descending order.
  always_comb begin
    a0 = (score[0] >= score[1]) ? score[0] : score[1];
    a1 = (score[0] >= score[1]) ? score[1] : score[0];
    a2 = (score[2] >= score[3]) ? score[2] : score[3];
    a3 = (score[2] >= score[3]) ? score[3] : score[2];
    b0 = (a0 >= a2) ? a0 : a2;
    b2 = (a0 >= a2) ? a2 : a0;
    b1 = (a1 >= a3) ? a1 : a3;
    s0 = b0;
    s1 = (b1 >= b2) ? b1 : b2;
    s2 = (b1 >= b2) ? b2 : b1;
  end

  // The smallest score is always zero when fewer than four neighbours are
  // present, so only the three largest enter the code.
  assign code = {5'b0, s2, 5'b0, s1, 5'b0, s0};

  // Table search; the first match wins.
  always_comb begin
    found       = 1'b0;
    match_index = '0;
    for (int k = nsc_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
      if (nsc_pkg::CLASS_CODES[k] == code) begin
        found       = 1'b1;
        match_index = nsc_pkg::CLASS_W'(k);
      end
    end
  end

  assign count_ok = (count != '0) && (count != nsc_pkg::COUNT_W'(4));

  // An empty centre, a bad neighbour count or a missing code is an error.
  always_comb begin
    if (req.centre_present && count_ok && found) begin
      res.class_index = match_index;
      res.is_error    = 1'b0;
      res.main_type   = count[nsc_pkg::MAIN_W-1:0];
    end else begin
      res.class_index = '0;
      res.is_error    = 1'b1;
      res.main_type   = '0;
    end
  end

endmodule

/* design/neighbour_shell_classifier.sv */
// Top level of the neighbour shell classifier: input and result registers.
//
// One request on the s_ channel carries a site's neighbourhood; one result
// leaves on the m_ channel for every request, in the same order.
// Each first neighbour that is present scores one plus its occupied second
// neighbours; the sorted scores select one of 31 classes. An empty centre,
// zero or four first neighbours, or no occupied second neighbour behind any
// present first neighbour gives an error result with class index and main
// type both zero.
// The request is captured in an input register; the scoring, sort and table
// lookup sit between it and the result register.
// Throughput: one request per cycle while the receiver keeps up, set by the
// two-register pipeline with no shared unit; both registers advance together
// whenever the result is taken or the result register is empty.
// When the receiver stalls, the result holds and the input register keeps
// one further request; s_tready then falls until the result is taken.
// Reset (rst, synchronous, active high) empties both registers.
module neighbour_shell_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, lowest bit up: centre_present[0], first_present[4:1],
  // second_present[16:5], zero padding[23:17]
  input  logic [nsc_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, lowest bit up: class_index[4:0], main_type[6:5], zero padding[7]
  output logic [nsc_pkg::OUT_DATA_W-1:0]  m_tdata,
  // m_tuser, lowest bit up: is_error[0]
  output logic                            m_tuser
);

  logic                  in_valid;
  nsc_pkg::nsc_request_t in_req;
  logic                  out_valid;
  nsc_pkg::nsc_result_t  out_res;
  nsc_pkg::nsc_result_t  res_next;
  logic                  out_free;
  logic                  in_take;

  // The result register can load when empty or when its result is taken.
  assign out_free = !out_valid || m_tready;
  assign s_tready = !in_valid || out_free;
  assign in_take  = s_tvalid && s_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req.centre_present <= s_tdata[0];
      in_req.first_present  <= s_tdata[4:1];
      in_req.second_present <= s_tdata[16:5];
    end
  end

  // Classification logic.
  nsc_classify u_classify (
    .req (in_req),
    .res (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.main_type, out_res.class_index};
  assign m_tuser  = out_res.is_error;

endmodule

/* design/nsc_checker.sv */
// Port-level checker for the neighbour shell classifier, bound to the top level.
module nsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [nsc_pkg::IN_DATA_W-1:0]   s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [nsc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tuser
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An error result carries zero class index and main type.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result with non-zero fields");

  // A good result has one to three neighbours and a class in range.
  a_good_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      m_tdata[6:5] != 2'd0 && m_tdata[4:0] != 5'd31 && m_tdata[7] == 1'b0)
    else $error("good result out of range");

  // A request accepted into an empty pipeline is answered once it has passed the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid && m_tready |=> ##1 m_tvalid)
    else $error("result missing after a request");

endmodule

bind neighbour_shell_classifier nsc_checker u_nsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/shell_class_checker.sv */
// Checker for the neighbour shell classifier: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module shell_class_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // s_tdata, lowest bit up: centre_present, first_present, second_present, padding
  input  logic [nsc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, lowest bit up: class_index, main_type, padding
  input  logic [nsc_pkg::OUT_DATA_W-1:0]  m_tdata,
  // m_tuser, lowest bit up: is_error
  input  logic                            m_tuser,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked,
  output int                              error_results,
  output int                              classes_hit
);

  // Sorted shell scores, largest in the lowest byte, listed in class order.
  localparam logic [23:0] SHELL_CODES [31] = '{
    24'h000002, 24'h000003, 24'h000004,
    24'h000102, 24'h000103, 24'h000104, 24'h000202, 24'h000203,
    24'h000204, 24'h000303, 24'h000304, 24'h000404,
    24'h010102, 24'h010103, 24'h010104, 24'h010202, 24'h010203,
    24'h010204, 24'h010303, 24'h010304, 24'h010404, 24'h020202,
    24'h020203, 24'h020204, 24'h020303, 24'h020304, 24'h020404,
    24'h030303, 24'h030304, 24'h030404, 24'h040404
  };

  nsc_pkg::nsc_result_t  expected_classes [$];
  nsc_pkg::nsc_result_t  want;
  nsc_pkg::nsc_result_t  got;
  nsc_pkg::nsc_request_t site;
  logic [30:0]           class_seen;
  int                    faults;
  int                    checked;
  int                    errors_seen;

  // Scores each first neighbour, sorts the scores and looks the shell pattern up.
  function automatic nsc_pkg::nsc_result_t classify_site(input nsc_pkg::nsc_request_t req);
    logic [2:0]           shell [4];
    logic [2:0]           group;
    logic [2:0]           swap;
    logic [23:0]          pattern;
    int                   present;
    bit                   matched;
    nsc_pkg::nsc_result_t res;
    present = 0;
    matched = 1'b0;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      group = req.second_present[3*k +: 3];
      shell[k] = 3'd0;
      if (req.first_present[k]) begin
        shell[k] = 3'd1 + group[0] + group[1] + group[2];
        present++;
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int m = k + 1; m < 4; m++) begin
        if (shell[k] < shell[m]) begin
          swap = shell[k];
          shell[k] = shell[m];
          shell[m] = swap;
        end
      end
    end
    // With at most three neighbours the smallest score is zero, so three bytes suffice.
    pattern = {5'b0, shell[2], 5'b0, shell[1], 5'b0, shell[0]};
    if (req.centre_present && present >= 1 && present <= 3) begin
      for (int i = 0; i < 31; i++) begin
        if (!matched && SHELL_CODES[i] == pattern) begin
          matched = 1'b1;
          res.class_index = i[4:0];
          res.main_type = present[1:0];
        end
      end
    end
    res.is_error = !matched;
    return res;
  endfunction

  initial begin
    faults = 0;
    checked = 0;
    errors_seen = 0;
    class_seen = '0;
    fail_count = 0;
    pending = 0;
    results_checked = 0;
    error_results = 0;
    classes_hit = 0;
  end

  // Results are handled before requests: a request never leaves in the cycle it arrives.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.class_index = m_tdata[4:0];
        got.main_type = m_tdata[6:5];
        got.is_error = m_tuser;
        if (expected_classes.size() == 0) begin
          faults++;
          if (faults <= 10) begin
            $display("%0t: result with no request outstanding (class %0d error %0b main %0d)",
                     $time, got.class_index, got.is_error, got.main_type);
          end
        end else begin
          want = expected_classes.pop_front();
          checked++;
          if (want.is_error) begin
            errors_seen++;
          end else begin
            class_seen[want.class_index] = 1'b1;
          end
          if (got.class_index !== want.class_index || got.is_error !== want.is_error ||
              got.main_type !== want.main_type) begin
            faults++;
            if (faults <= 10) begin
              $display("%0t: mismatch, expected class %0d error %0b main %0d, got %0d %0b %0d",
                       $time, want.class_index, want.is_error, want.main_type,
                       got.class_index, got.is_error, got.main_type);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        site.centre_present = s_tdata[0];
        site.first_present = s_tdata[4:1];
        site.second_present = s_tdata[16:5];
        expected_classes.push_back(classify_site(site));
      end
      pending <= expected_classes.size();
      fail_count <= faults;
      results_checked <= checked;
      error_results <= errors_seen;
      classes_hit <= $countones(class_seen);
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the neighbour shell classifier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  // s_tdata, lowest bit up: centre_present, first_present, second_present, padding
  logic [nsc_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  // m_tdata, lowest bit up: class_index, main_type, padding
  logic [nsc_pkg::OUT_DATA_W-1:0] m_tdata;
  // m_tuser, lowest bit up: is_error
  logic                           m_tuser;

  int fail_count;
  int pending;
  int results_checked;
  int error_results;
  int classes_hit;
  int sites_sent;
  bit quiet_run;
  int hold_asks;

  neighbour_shell_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  shell_class_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .error_results   (error_results),
    .classes_hit     (classes_hit)
  );

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic nsc_pkg::nsc_request_t make_site(input logic centre,
                                                      input logic [3:0] first,
                                                      input logic [11:0] second);
    nsc_pkg::nsc_request_t req;
    req.centre_present = centre;
    req.first_present = first;
    req.second_present = second;
    return req;
  endfunction

  // Mostly well-formed neighbourhoods with shells biased to empty or full; the rest is noise.
  function automatic nsc_pkg::nsc_request_t draw_site();
    nsc_pkg::nsc_request_t req;
    int                    shape;
    req.centre_present = 1'($urandom_range(0, 1));
    req.first_present = 4'($urandom_range(0, 15));
    req.second_present = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 99) < 80) begin
      req.centre_present = 1'b1;
      req.first_present = 4'($urandom_range(1, 14));
      for (int k = 0; k < 4; k++) begin
        shape = $urandom_range(0, 3);
        if (shape == 0) begin
          req.second_present[3*k +: 3] = 3'b000;
        end else if (shape == 1) begin
          req.second_present[3*k +: 3] = 3'b111;
        end
      end
    end
    return req;
  endfunction

  // Offers one request after a random gap (none during a quiet run) and waits until it is taken.
  task automatic offer_site(input nsc_pkg::nsc_request_t req);
    int gap;
    gap = quiet_run ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, req.second_present, req.first_present, req.centre_present};
    do @(posedge clk); while (!s_tready);
    sites_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: random stalls outside quiet runs, with a long hold-off whenever one is asked for.
  initial begin
    int stall;
    int holds_done;
    holds_done = 0;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = quiet_run ? 0 : $urandom_range(0, 19);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        stall = 200;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stimulus and verdict.
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sites_sent = 0;
    quiet_run = 1'b0;
    hold_asks = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed cases: error conditions, ignored shells and the class extremes.
    offer_site(make_site(1'b0, 4'b0111, 12'h0FF));
    offer_site(make_site(1'b1, 4'b0000, 12'hFFF));
    offer_site(make_site(1'b1, 4'b1111, 12'hFFF));
    offer_site(make_site(1'b1, 4'b1111, 12'h000));
    offer_site(make_site(1'b1, 4'b0001, 12'h000));
    offer_site(make_site(1'b1, 4'b0111, 12'h000));
    offer_site(make_site(1'b1, 4'b0001, 12'hFF8));
    offer_site(make_site(1'b1, 4'b0001, 12'h001));
    offer_site(make_site(1'b1, 4'b0001, 12'h007));
    offer_site(make_site(1'b1, 4'b1000, 12'hE00));
    offer_site(make_site(1'b1, 4'b0111, 12'hFFF));
    offer_site(make_site(1'b1, 4'b1110, 12'hFFF));
    offer_site(make_site(1'b1, 4'b0011, 12'h03F));
    offer_site(make_site(1'b1, 4'b0101, 12'h1C1));
    offer_site(make_site(1'b1, 4'b0110, 12'h038));
    offer_site(make_site(1'b1, 4'b1011, 12'h249));
    offer_site(make_site(1'b0, 4'b0000, 12'h000));
    offer_site(make_site(1'b1, 4'b1010, 12'h555));
    offer_site(make_site(1'b0, 4'b1111, 12'hFFF));
    offer_site(make_site(1'b1, 4'b1001, 12'hAAA));

    // Random traffic with idling on both sides.
    repeat (700) offer_site(draw_site());

    // Long receiver hold-off while requests keep coming, then a full drain.
    hold_asks++;
    quiet_run = 1'b1;
    repeat (40) offer_site(draw_site());
    quiet_run = 1'b0;
    drain_results();

    // A stretch at full rate, then more traffic with idling.
    quiet_run = 1'b1;
    repeat (250) offer_site(draw_site());
    quiet_run = 1'b0;
    repeat (740) offer_site(draw_site());

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d site requests; %0d results checked, %0d of them errors.",
             sites_sent, results_checked, error_results);
    $display("Valid classes reached: %0d of 31.", classes_hit);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
